FILE: rtl/cbscrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbscrc_pkg
// Shared types and constants of the configurable bit-serial crc unit.
// ----------------------------------------------------------------------------
package cbscrc_pkg;

    // fixed field widths
    localparam int CRC_W     = 64;
    localparam int WIDTH_W   = 7;
    localparam int DATA_W    = 8;
    localparam int CFG_IDX_W = 4;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // configuration register indexes
    localparam cfg_idx_t CFG_POLYNOMIAL  = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_WIDTH       = cfg_idx_t'(1);
    localparam cfg_idx_t CFG_INIT_FILL   = cfg_idx_t'(2);
    localparam cfg_idx_t CFG_REFLECT_IN  = cfg_idx_t'(3);
    localparam cfg_idx_t CFG_REFLECT_OUT = cfg_idx_t'(4);
    localparam cfg_idx_t CFG_INVERT_OUT  = cfg_idx_t'(5);
    localparam cfg_idx_t CFG_DIRECT_MODE = cfg_idx_t'(6);
    localparam cfg_idx_t CFG_PAD_EN      = cfg_idx_t'(7);

    // reset values of the configuration
    localparam logic [CRC_W-1:0]   POLY_RESET  = 64'h0000_0000_04C1_1DB7;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd32;

    typedef struct packed {
        logic [CRC_W-1:0]   poly;
        logic [WIDTH_W-1:0] width;
        logic               init_fill;
        logic               reflect_in;
        logic               reflect_out;
        logic               invert_out;
        logic               direct_mode;
        logic               pad_en;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic pad_step;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [WIDTH_W-1:0] eff_w;
        logic               pad_en;
    } dp_stat_t;

endpackage

FILE: rtl/configurable_bit_serial_crc_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// configurable_bit_serial_crc_unit
// Parameterized CRC engine, 1 to MAX_WIDTH bits, byte items in, CRC out.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_ready with data_byte, first, last. first loads
//   the initial fill before the item, last finishes the message.
//   output channel: out_valid/out_ready with crc_value, one item per message,
//   right-aligned in the low width bits.
//   config channel: cfg_valid/cfg_ready with cfg_index/cfg_data, always ready;
//   write only while no message is in flight.
//   throughput: one item per cycle while idle; the item step is unrolled
//   combinationally over BITS_PER_ITEM lfsr clocks.
//   finish: a last item leads to the finish state, which loads the result
//   once the output is free; padding runs first, one pad bit per cycle.
//   in_ready drops from the last item until its CRC is in the output register.
//   receiver stall: the result waits in the output register while new items
//   keep streaming in; only a following last item waits for it to drain.
//   reset: configuration returns to its defaults (crc-32 style), the shift
//   register clears and the output channel empties.
// ----------------------------------------------------------------------------
module configurable_bit_serial_crc_unit #(
    parameter int MAX_WIDTH     = 64,
    parameter int BITS_PER_ITEM = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [cbscrc_pkg::DATA_W-1:0]  data_byte,
    input  logic                           first,
    input  logic                           last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cbscrc_pkg::CRC_W-1:0]   crc_value,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  cbscrc_pkg::cfg_idx_t           cfg_index,
    input  logic [cbscrc_pkg::CRC_W-1:0]   cfg_data
);
    import cbscrc_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // configuration registers
    cbscrc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer
    cbscrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // crc datapath
    cbscrc_dp #(
        .MAX_WIDTH     (MAX_WIDTH),
        .BITS_PER_ITEM (BITS_PER_ITEM)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .stat      (stat),
        .data_byte (data_byte),
        .first     (first),
        .crc_value (crc_value)
    );

endmodule

FILE: rtl/cbscrc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbscrc_regs
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module cbscrc_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  cbscrc_pkg::cfg_idx_t        cfg_index,
    input  logic [cbscrc_pkg::CRC_W-1:0] cfg_data,
    output cbscrc_pkg::cfg_t            cfg
);
    import cbscrc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // register decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_POLYNOMIAL:  cfg_next.poly        = cfg_data;
                CFG_WIDTH:       cfg_next.width       = cfg_data[WIDTH_W-1:0];
                CFG_INIT_FILL:   cfg_next.init_fill   = cfg_data[0];
                CFG_REFLECT_IN:  cfg_next.reflect_in  = cfg_data[0];
                CFG_REFLECT_OUT: cfg_next.reflect_out = cfg_data[0];
                CFG_INVERT_OUT:  cfg_next.invert_out  = cfg_data[0];
                CFG_DIRECT_MODE: cfg_next.direct_mode = cfg_data[0];
                CFG_PAD_EN:      cfg_next.pad_en      = cfg_data[0];
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poly        <= POLY_RESET;
            cfg_reg.width       <= WIDTH_RESET;
            cfg_reg.init_fill   <= 1'b1;
            cfg_reg.reflect_in  <= 1'b1;
            cfg_reg.reflect_out <= 1'b1;
            cfg_reg.invert_out  <= 1'b1;
            cfg_reg.direct_mode <= 1'b1;
            cfg_reg.pad_en      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/cbscrc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbscrc_dp
// CRC datapath: shift register with an unrolled per-item step, a one-bit pad
// step, and the finishing inversion / reflection into the result register.
// ----------------------------------------------------------------------------
module cbscrc_dp #(
    parameter int MAX_WIDTH     = 64,
    parameter int BITS_PER_ITEM = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cbscrc_pkg::cfg_t              cfg,
    input  cbscrc_pkg::dp_cmd_t           cmd,
    output cbscrc_pkg::dp_stat_t          stat,
    input  logic [cbscrc_pkg::DATA_W-1:0] data_byte,
    input  logic                          first,
    output logic [cbscrc_pkg::CRC_W-1:0]  crc_value
);
    import cbscrc_pkg::*;

    localparam int IDX_W = $clog2(MAX_WIDTH);
    localparam logic [WIDTH_W-1:0] MAX_W_L = WIDTH_W'(MAX_WIDTH);

    logic [MAX_WIDTH-1:0] shift_reg;
    logic [MAX_WIDTH-1:0] shift_next;
    logic [CRC_W-1:0]     crc_value_reg;
    logic [CRC_W-1:0]     crc_value_next;

    logic [WIDTH_W-1:0]   eff_w;
    logic [WIDTH_W-1:0]   w_gap;
    logic [WIDTH_W-1:0]   w_top;
    logic [IDX_W-1:0]     top_idx;
    logic [MAX_WIDTH-1:0] mask;
    logic [MAX_WIDTH-1:0] poly_m;
    logic [MAX_WIDTH-1:0] cur;
    logic [MAX_WIDTH-1:0] stage [BITS_PER_ITEM+1];
    logic [MAX_WIDTH-1:0] pad_val;
    logic [MAX_WIDTH-1:0] res_inv;
    logic [MAX_WIDTH-1:0] res_rev;
    logic [MAX_WIDTH-1:0] res_fin;

    // one lfsr clock, s is already masked to the width
    function automatic logic [MAX_WIDTH-1:0] lfsr_step(
        input logic [MAX_WIDTH-1:0] s,
        input logic                 bit_in,
        input logic [MAX_WIDTH-1:0] msk,
        input logic [MAX_WIDTH-1:0] pm,
        input logic [IDX_W-1:0]     tidx,
        input logic                 direct
    );
        logic                 fb;
        logic [MAX_WIDTH-1:0] n;
        fb = s[tidx] ^ (direct & bit_in);
        n  = (s << 1) & msk;
        if (fb)
            n = n ^ pm;
        if (!direct)
            n[0] = n[0] ^ bit_in;
        return n;
    endfunction

    // effective width, clamped to one and to the register size
    always_comb
    begin
        if (cfg.width == '0)
            eff_w = WIDTH_W'(1);
        else if (cfg.width > MAX_W_L)
            eff_w = MAX_W_L;
        else
            eff_w = cfg.width;
    end

    assign w_gap   = MAX_W_L - eff_w;
    assign w_top   = eff_w - WIDTH_W'(1);
    assign top_idx = w_top[IDX_W-1:0];
    assign mask    = {MAX_WIDTH{1'b1}} >> w_gap[IDX_W-1:0];
    assign poly_m  = cfg.poly[MAX_WIDTH-1:0] & mask;

    // item step: optional fill load, then one lfsr clock per item bit
    always_comb
    begin
        if (first)
            cur = cfg.init_fill ? mask : '0;
        else
            cur = shift_reg & mask;
        stage[0] = cur;
        for (int i = 0; i < BITS_PER_ITEM; i++)
        begin
            stage[i+1] = lfsr_step(stage[i],
                data_byte[cfg.reflect_in ? 3'(i) : 3'(BITS_PER_ITEM - 1 - i)],
                mask, poly_m, top_idx, cfg.direct_mode);
        end
    end

    // pad step clocks in a single zero bit
    assign pad_val = lfsr_step(shift_reg & mask, 1'b0, mask, poly_m, top_idx,
                               cfg.direct_mode);

    // finishing: invert, then reverse the low width bits
    always_comb
    begin
        res_inv = shift_reg & mask;
        if (cfg.invert_out)
            res_inv = ~res_inv & mask;
        for (int i = 0; i < MAX_WIDTH; i++)
            res_rev[i] = res_inv[MAX_WIDTH-1-i];
        res_fin = cfg.reflect_out ? (res_rev >> w_gap[IDX_W-1:0]) : res_inv;
    end

    // register updates
    always_comb
    begin
        if (cmd.load_item)
            shift_next = stage[BITS_PER_ITEM];
        else if (cmd.pad_step)
            shift_next = pad_val;
        else
            shift_next = shift_reg;
        crc_value_next = cmd.load_out ? CRC_W'(res_fin) : crc_value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            shift_reg <= '0;
        else
            shift_reg <= shift_next;
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        crc_value_reg <= crc_value_next;
    end

    assign crc_value   = crc_value_reg;
    assign stat.eff_w  = eff_w;
    assign stat.pad_en = cfg.pad_en;

endmodule

FILE: rtl/cbscrc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbscrc_ctrl
// Sequencer: takes items, runs the zero padding count and hands the finished
// CRC to the output register.
// ----------------------------------------------------------------------------
module cbscrc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  cbscrc_pkg::dp_stat_t stat,
    output cbscrc_pkg::dp_cmd_t  cmd
);
    import cbscrc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_FINISH
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [WIDTH_W-1:0] pad_cnt_reg;
    logic [WIDTH_W-1:0] pad_cnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               in_fire;
    logic               out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        pad_cnt_next   = pad_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load_item = 1'b1;
                    if (last)
                    begin
                        if (stat.pad_en)
                        begin
                            state_next   = S_PAD;
                            pad_cnt_next = stat.eff_w;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                end
            end
            S_PAD:
            begin
                cmd.pad_step = 1'b1;
                pad_cnt_next = pad_cnt_reg - WIDTH_W'(1);
                if (pad_cnt_reg == WIDTH_W'(1))
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pad_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pad_cnt_reg   <= pad_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register loaded while still full");

    // the pad count never runs dry inside the pad phase
    a_pad_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAD) |-> (pad_cnt_reg != '0))
        else $error("pad phase with zero count");

    // a last item with padding enters the pad phase
    a_pad_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last && stat.pad_en) |=> (state_reg == S_PAD))
        else $error("padding skipped after last item");

    // datapath commands are exclusive
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_item, cmd.pad_step, cmd.load_out}))
        else $error("more than one datapath command");
`endif

endmodule

FILE: bench/configurable_bit_serial_crc_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// configurable_bit_serial_crc_unit_tb
// Streams byte messages through the crc unit under a series of register
// settings (reset crc-32, crc-8, 64-bit, augmented with zero padding, width
// extremes and random settings) and checks every crc against a bit-serial
// model of the engine kept in a scoreboard. Both channels idle at random;
// one long output stall fills the unit, and one pause drains it.
// ----------------------------------------------------------------------------
module configurable_bit_serial_crc_unit_tb;

    import cbscrc_pkg::*;

    localparam int MAX_WIDTH     = 64;
    localparam int BITS_PER_ITEM = 8;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 80;
    localparam int STALL_CYCLES  = 400;
    localparam int IDX_TOP       = (1 << CFG_IDX_W) - 1;

    // crc engine model and queue of crcs still owed by the unit
    class crc_tracker;
        logic [CRC_W-1:0]   poly;
        logic [WIDTH_W-1:0] width_reg;
        bit                 init_ones;
        bit                 lsb_first;
        bit                 flip_out;
        bit                 invert;
        bit                 direct;
        bit                 pad_zeros;
        logic [CRC_W-1:0]   crc_reg;
        logic [CRC_W-1:0]   crc_due[$];
        int                 errors;

        function new();
            poly      = POLY_RESET;
            width_reg = WIDTH_RESET;
            init_ones = 1'b1;
            lsb_first = 1'b1;
            flip_out  = 1'b1;
            invert    = 1'b1;
            direct    = 1'b1;
            pad_zeros = 1'b0;
            crc_reg   = '0;
            errors    = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CRC_W-1:0] d);
            case (idx)
                CFG_POLYNOMIAL:  poly = d;
                CFG_WIDTH:       width_reg = d[WIDTH_W-1:0];
                CFG_INIT_FILL:   init_ones = d[0];
                CFG_REFLECT_IN:  lsb_first = d[0];
                CFG_REFLECT_OUT: flip_out = d[0];
                CFG_INVERT_OUT:  invert = d[0];
                CFG_DIRECT_MODE: direct = d[0];
                CFG_PAD_EN:      pad_zeros = d[0];
                default:         ;
            endcase
        endfunction

        // one lfsr clock
        function void clock_bit(bit din, int w, logic [CRC_W-1:0] mask);
            bit fb;
            fb = crc_reg[w-1] ^ (direct & din);
            crc_reg = (crc_reg << 1) & mask;
            if (fb)
                crc_reg = crc_reg ^ (poly & mask);
            if (!direct)
                crc_reg = crc_reg ^ CRC_W'(din);
            crc_reg = crc_reg & mask;
        endfunction

        function void note_item(logic [DATA_W-1:0] b, bit f, bit l);
            int               w;
            logic [CRC_W-1:0] mask;
            logic [CRC_W-1:0] res;
            logic [CRC_W-1:0] flipped;
            w = width_reg;
            if (w < 1)
                w = 1;
            if (w > MAX_WIDTH)
                w = MAX_WIDTH;
            mask = (w >= CRC_W) ? '1 : ((64'd1 << w) - 64'd1);
            if (f)
                crc_reg = init_ones ? mask : '0;
            crc_reg = crc_reg & mask;
            for (int i = 0; i < BITS_PER_ITEM; i++)
                clock_bit(b[lsb_first ? i : BITS_PER_ITEM - 1 - i], w, mask);
            if (!l)
                return;
            // finish: padding moves the register, inversion and reflection do not
            if (pad_zeros)
                for (int i = 0; i < w; i++)
                    clock_bit(1'b0, w, mask);
            res = crc_reg & mask;
            if (invert)
                res = ~res & mask;
            if (flip_out)
            begin
                flipped = '0;
                for (int i = 0; i < w; i++)
                    flipped[w-1-i] = res[i];
                res = flipped;
            end
            crc_due.insert(crc_due.size(), res);
        endfunction

        function void check_crc(logic [CRC_W-1:0] got);
            logic [CRC_W-1:0] want;
            if (crc_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("crc_value %h arrived with no crc pending", got);
                return;
            end
            want = crc_due.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("crc_value mismatch: expected %h, got %h", want, got);
            end
        endfunction

        function int pending();
            return crc_due.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [DATA_W-1:0]    data_byte;
    logic                 first;
    logic                 last;
    logic                 out_valid;
    logic                 out_ready;
    logic [CRC_W-1:0]     crc_value;
    logic                 cfg_valid;
    logic                 cfg_ready;
    cfg_idx_t             cfg_index;
    logic [CRC_W-1:0]     cfg_data;

    crc_tracker           sb = new();
    int                   cycle_count = 0;
    bit                   send_fast = 1'b0;
    bit                   take_fast = 1'b0;
    bit                   stall_request = 1'b0;

    configurable_bit_serial_crc_unit #(
        .MAX_WIDTH     (MAX_WIDTH),
        .BITS_PER_ITEM (BITS_PER_ITEM)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .first     (first),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .crc_value (crc_value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("configurable_bit_serial_crc_unit_tb: errors");
        $finish;
    end

    // accepted register writes, items and crcs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_item(data_byte, first, last);
            if (out_valid && out_ready)
                sb.check_crc(crc_value);
        end
    end

    // result receiver: random waits, one long hold-off on request
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (stall_request)
            begin
                out_ready = 1'b0;
                repeat (STALL_CYCLES) @(negedge clk);
                stall_request = 1'b0;
            end
            if ($urandom_range(0, 19) == 0)
                take_fast = !take_fast;
            gap = take_fast ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // offer one item; valid stays high after acceptance unless the next gap lowers it
    task automatic send_item(logic [DATA_W-1:0] b, bit f, bit l);
        int gap;
        if ($urandom_range(0, 19) == 0)
            send_fast = !send_fast;
        gap = send_fast ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        data_byte = b;
        first     = f;
        last      = l;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // stop offering and wait until every crc has been taken
    task automatic wait_drained();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CRC_W-1:0] d);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // random upper bits above the field, which the unit must drop
    function automatic logic [CRC_W-1:0] with_junk(logic [CRC_W-1:0] v, int keep);
        logic [CRC_W-1:0] keep_mask;
        keep_mask = (64'd1 << keep) - 64'd1;
        return ({$urandom, $urandom} & ~keep_mask) | (v & keep_mask);
    endfunction

    // full register set, written only with the unit idle
    task automatic set_config(logic [CRC_W-1:0] p, logic [WIDTH_W-1:0] w, bit fill,
                              bit rin, bit rout, bit inv, bit dir, bit pad);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(CFG_POLYNOMIAL, p);
        write_reg(CFG_WIDTH, with_junk(CRC_W'(w), WIDTH_W));
        write_reg(CFG_INIT_FILL, with_junk(CRC_W'(fill), 1));
        write_reg(CFG_REFLECT_IN, with_junk(CRC_W'(rin), 1));
        write_reg(CFG_REFLECT_OUT, with_junk(CRC_W'(rout), 1));
        write_reg(CFG_INVERT_OUT, with_junk(CRC_W'(inv), 1));
        write_reg(CFG_DIRECT_MODE, with_junk(CRC_W'(dir), 1));
        write_reg(CFG_PAD_EN, with_junk(CRC_W'(pad), 1));
        // unused index, must be ignored
        write_reg(cfg_idx_t'($urandom_range(int'(CFG_PAD_EN) + 1, IDX_TOP)),
                  {$urandom, $urandom});
    endtask

    // random messages, mostly well formed, some missing first or last
    task automatic send_messages(int n_items);
        int  sent;
        int  len;
        int  kind;
        int  extra_first;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            kind = $urandom_range(0, 9);
            extra_first = $urandom_range(0, len - 1);
            for (int k = 0; k < len; k++)
            begin
                send_item(DATA_W'($urandom),
                          (k == 0 && kind != 0) || (kind == 1 && k == extra_first),
                          (k == len - 1) && kind != 2);
                sent++;
            end
        end
    endtask

    // main sequence
    initial
    begin
        logic [CRC_W-1:0]   p;
        logic [WIDTH_W-1:0] w;
        in_valid  = 1'b0;
        data_byte = '0;
        first     = 1'b0;
        last      = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_POLYNOMIAL;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings (crc-32): check string, byte extremes, missing and repeated first
        for (int k = 0; k < 9; k++)
            send_item(DATA_W'(8'h31 + k), k == 0, k == 8);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h01, 1'b0, 1'b0);
        send_item(8'h5A, 1'b1, 1'b0);
        send_item(8'hC3, 1'b0, 1'b1);

        // crc-8, msb first, plain output
        set_config(64'h07, 7'd8, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_messages(50);

        // full 64-bit register
        set_config(64'h42F0_E1EB_A9EA_3693, 7'd64, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        send_messages(50);

        // augmented 16-bit with zero padding
        set_config(64'h1021, 7'd16, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_messages(50);

        // single-bit crc, augmented with padding
        set_config(64'h1, 7'd1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
        send_messages(50);

        // width zero acts as one
        set_config('1, 7'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
        send_messages(50);

        // width at its top code acts as the maximum, all-ones polynomial
        set_config('1, 7'd127, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
        send_messages(50);

        // width just over the maximum, zero polynomial
        set_config('0, 7'd65, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
        send_messages(50);

        // longest finish: 64-bit augmented with padding
        set_config({$urandom, $urandom}, 7'd64, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
        send_messages(50);

        // random settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case ($urandom_range(0, 9))
                0:       w = 7'd0;
                1:       w = WIDTH_W'($urandom_range(65, 127));
                2:       w = 7'd64;
                default: w = WIDTH_W'($urandom_range(1, 64));
            endcase
            case ($urandom_range(0, 7))
                0:       p = '0;
                1:       p = '1;
                default: p = {$urandom, $urandom};
            endcase
            set_config(p, w, $urandom_range(0, 1), $urandom_range(0, 1),
                       $urandom_range(0, 1), $urandom_range(0, 1),
                       $urandom_range(0, 1), $urandom_range(0, 1));
            if (ph == 0)
                stall_request = 1'b1;
            if (ph == 1)
            begin
                send_messages(40);
                wait_drained();
                send_messages(45);
            end
            else
            begin
                send_messages(85);
            end
        end

        // drain and let the unit settle
        wait_drained();
        repeat (END_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("configurable_bit_serial_crc_unit_tb: clean");
        end
        else
        begin
            $display("configurable_bit_serial_crc_unit_tb: errors");
        end
        $finish;
    end

endmodule
